FILE: src/ess_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ess_pkg
// Types and constants shared by the exact substring search block.
// ----------------------------------------------------------------------------
package ess_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned IdxW       = $clog2(MaxPattern);
  localparam int unsigned LenW       = 7;
  localparam int unsigned PidxW      = 6;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned OutW       = 32;
  localparam int unsigned FifoDepth  = 3;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic OpLoad     = 1'b0;
  localparam logic OpHaystack = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic shift;
    logic clr;
    logic rot;
  } cell_ctrl_t;

  typedef struct packed {
    logic            found;
    logic [OutW-1:0] offset;
  } result_t;

endpackage

FILE: src/ess_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ess_stream_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ess_in_if;
  import ess_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [PidxW-1:0] pattern_index;
  logic [7:0]       data_byte;
  logic             last_byte;

  modport source (output valid, op, pattern_index, data_byte, last_byte, input ready);
  modport sink   (input valid, op, pattern_index, data_byte, last_byte, output ready);
endinterface

interface ess_out_if;
  import ess_pkg::*;
  logic            valid;
  logic            ready;
  logic            found;
  logic [OutW-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink   (input valid, found, match_offset, output ready);
endinterface

FILE: src/ess_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ess_cell
// One window position: haystack byte, aligned pattern byte and comparator.
// ----------------------------------------------------------------------------
module ess_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ess_pkg::cell_ctrl_t ctrl_i,
  input  logic               load_sel_i,
  input  logic               cmp_en_i,
  input  ess_pkg::byte_t     win_in_i,
  input  ess_pkg::byte_t     pat_in_i,
  input  ess_pkg::byte_t     load_byte_i,
  output ess_pkg::byte_t     win_o,
  output ess_pkg::byte_t     pat_o,
  output logic               miss_o
);
  import ess_pkg::*;

  byte_t win_q, win_d;
  byte_t pat_q, pat_d;

  always_comb begin
    if (ctrl_i.shift) begin
      win_d = win_in_i;
    end else if (ctrl_i.clr) begin
      win_d = '0;
    end else begin
      win_d = win_q;
    end
  end

  always_comb begin
    if (ctrl_i.rot) begin
      pat_d = pat_in_i;
    end else if (load_sel_i) begin
      pat_d = load_byte_i;
    end else begin
      pat_d = pat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  assign win_o  = win_q;
  assign pat_o  = pat_q;
  assign miss_o = cmp_en_i && (win_q != pat_q);

endmodule

FILE: src/ess_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ess_out_fifo
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module ess_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  ess_pkg::result_t                  data_i,
  output logic [ess_pkg::FifoCntW-1:0]      cnt_o,
  ess_out_if.source                         out_o
);
  import ess_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, wr_d;
  logic [FifoPtrW-1:0]   rd_q, rd_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + FifoPtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + FifoPtrW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign cnt_o              = cnt_q;
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.found        = mem_q[rd_q].found;
  assign out_o.match_offset = mem_q[rd_q].offset;

endmodule

FILE: src/exact_substring_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exact_substring_search_top
// First exact match of a loaded pattern in a streamed haystack.
// ----------------------------------------------------------------------------
// Takes one item per cycle. A haystack byte is shifted into a row of 64 cells
// and compared against the pattern in the following cycle; its result, if
// any, is pushed into a three-item queue that feeds the output. The input
// is held off while that queue, counting a result still being evaluated, is
// full. Pattern bytes are kept in the cells rotated to suit the current
// pattern length: after a length write the ring turns one place per cycle
// until aligned, and the input is held off meanwhile.
// ----------------------------------------------------------------------------
module exact_substring_search_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ess_pkg::LenW-1:0]  cfg_wdata_i,
  ess_in_if.sink                    in_i,
  ess_out_if.source                 out_o
);
  import ess_pkg::*;

  logic [LenW-1:0]       len_q, len_d, len_c;
  logic [IdxW-1:0]       align_q, align_d, target;
  logic [OffsetBits-1:0] bs_q, bs_d, bs_base, bs_inc;
  logic                  done_q, done_d;
  logic                  eval_q, ev_last_q;
  logic                  rot, acc, hay, ld, idx_ok;
  logic                  all_eq, hit, end_now, done_eff, shift, drop_end, clr;
  logic [IdxW:0]         addr_sum;
  logic [IdxW-1:0]       ld_addr;
  logic [FifoCntW-1:0]   fifo_cnt;
  logic [FifoCntW:0]     occ;
  logic [MaxPattern-1:0] miss;
  byte_t                 win   [MaxPattern];
  byte_t                 pat   [MaxPattern];
  cell_ctrl_t            ctrl;
  result_t               res;
  logic [OffsetBits-1:0] off;

  assign len_c  = (len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : len_q;
  assign target = (len_c == LenW'(MaxPattern)) ? '0 : len_c[IdxW-1:0];
  assign rot    = (align_q != target);

  assign occ      = {1'b0, fifo_cnt} + (FifoCntW + 1)'(eval_q);
  assign in_i.ready = !rot && (occ < (FifoCntW + 1)'(FifoDepth));
  assign acc      = in_i.valid && in_i.ready;
  assign hay      = acc && (in_i.op == OpHaystack);
  assign ld       = acc && (in_i.op == OpLoad);

  assign all_eq   = ~|miss;
  assign hit      = eval_q && ((len_c == '0) ||
                    ((bs_q >= OffsetBits'(len_c)) && all_eq));
  assign end_now  = eval_q && ev_last_q;
  assign done_eff = !end_now && (done_q || hit);
  assign shift    = hay && !done_eff;
  assign drop_end = hay && done_eff && in_i.last_byte;
  assign clr      = end_now || drop_end;

  assign ctrl.shift = shift;
  assign ctrl.clr   = clr;
  assign ctrl.rot   = rot;

  assign bs_base = end_now ? '0 : bs_q;
  assign bs_inc  = (&bs_base) ? bs_base : bs_base + OffsetBits'(1);

  always_comb begin
    if (shift) begin
      bs_d = bs_inc;
    end else if (drop_end) begin
      bs_d = '0;
    end else begin
      bs_d = bs_base;
    end
  end

  always_comb begin
    if (clr) begin
      done_d = 1'b0;
    end else if (hit) begin
      done_d = 1'b1;
    end else begin
      done_d = done_q;
    end
  end

  always_comb begin
    len_d   = cfg_we_i ? cfg_wdata_i : len_q;
    align_d = align_q;
    if (rot) begin
      align_d = (align_q == IdxW'(MaxPattern - 1)) ? '0 : align_q + IdxW'(1);
    end
  end

  // pattern byte i sits in cell (i - align) mod depth
  assign idx_ok   = (int'(in_i.pattern_index) < MaxPattern);
  assign addr_sum = (IdxW + 1)'(in_i.pattern_index) + (IdxW + 1)'(MaxPattern)
                    - {1'b0, align_q};
  assign ld_addr  = (addr_sum >= (IdxW + 1)'(MaxPattern)) ?
                    IdxW'(addr_sum - (IdxW + 1)'(MaxPattern)) : addr_sum[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LenW'(1);
      align_q <= IdxW'(1);
      bs_q    <= '0;
      done_q  <= 1'b0;
      eval_q  <= 1'b0;
    end else begin
      len_q   <= len_d;
      align_q <= align_d;
      bs_q    <= bs_d;
      done_q  <= done_d;
      eval_q  <= shift;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      ev_last_q <= in_i.last_byte;
    end
  end

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    byte_t win_in;
    logic  cmp_en, load_sel;

    if (j == MaxPattern - 1) begin : g_head
      assign win_in = in_i.data_byte;
    end else begin : g_body
      assign win_in = clr ? '0 : win[j+1];
    end

    assign cmp_en   = (LenW'(j) >= (LenW'(MaxPattern) - len_c));
    assign load_sel = ld && idx_ok && (ld_addr == IdxW'(j));

    ess_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_sel_i  (load_sel),
      .cmp_en_i    (cmp_en),
      .win_in_i    (win_in),
      .pat_in_i    (pat[(j + 1) % MaxPattern]),
      .load_byte_i (in_i.data_byte),
      .win_o       (win[j]),
      .pat_o       (pat[j]),
      .miss_o      (miss[j])
    );
  end

  assign off        = (hit && (len_c != '0)) ? bs_q - OffsetBits'(len_c) : '0;
  assign res.found  = hit;
  assign res.offset = OutW'(off);

  ess_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (hit || end_now),
    .data_i (res),
    .cnt_o  (fifo_cnt),
    .out_o  (out_o)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for exact_substring_search_top.
// ----------------------------------------------------------------------------
// Loads patterns, streams haystacks with planted, natural, missing and too
// short matches, and checks every result item against a local model of the
// search. The random blocks run under several pattern lengths and under four
// handshake regimes: free flowing, sender gaps, receiver stalls, and both.
// ----------------------------------------------------------------------------
module tb;
  import ess_pkg::*;

  localparam int SettleCycles  = 8;
  localparam int QuietLimit    = 4000;
  localparam int ItemsPerBlock = 66;
  localparam int BlocksPerPhase = 6;

  typedef struct packed {
    logic             op;
    logic [PidxW-1:0] idx;
    byte_t            data;
    logic             last;
  } search_item_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;

  ess_in_if  in_if ();
  ess_out_if out_if ();

  exact_substring_search_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  search_item_t pending_items[$];
  result_t      expected_results[$];
  search_item_t cur_item;
  int           send_gap_pct;
  int           sink_stall_pct;
  int           fail_count;

  // search model state
  byte_t           model_pattern [MaxPattern];
  byte_t           model_window  [MaxPattern];
  logic [31:0]     model_count;
  bit              model_done;
  logic [LenW-1:0] model_len;

  // stimulus generator state
  byte_t gen_pat [MaxPattern];
  byte_t gen_alpha [3];
  int    gen_eff;
  int    counted;

  function automatic void clear_search();
    for (int i = 0; i < MaxPattern; i++) model_window[i] = '0;
    model_count = '0;
    model_done  = 1'b0;
  endfunction

  function automatic void advance_search(search_item_t it);
    int      eff;
    bit      hit;
    bit      same;
    result_t r;
    hit = 1'b0;
    r.found  = 1'b0;
    r.offset = '0;
    if (it.op == OpLoad) begin
      model_pattern[it.idx] = it.data;
      return;
    end
    if (model_done) begin
      if (it.last) clear_search();
      return;
    end
    for (int i = 0; i < MaxPattern - 1; i++) model_window[i] = model_window[i+1];
    model_window[MaxPattern-1] = it.data;
    if (model_count != '1) model_count = model_count + 1;
    eff = (model_len > MaxPattern) ? MaxPattern : int'(model_len);
    if (eff == 0) begin
      hit = 1'b1;
    end else if (model_count >= eff) begin
      same = 1'b1;
      for (int i = 0; i < eff; i++) begin
        if (model_window[MaxPattern-eff+i] != model_pattern[i]) same = 1'b0;
      end
      if (same) begin
        hit = 1'b1;
        r.offset = model_count - eff;
      end
    end
    if (hit) begin
      r.found = 1'b1;
      expected_results.push_back(r);
      if (it.last) clear_search();
      else model_done = 1'b1;
    end else if (it.last) begin
      expected_results.push_back(r);
      clear_search();
    end
  endfunction

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.op       = OpLoad;
    in_if.pattern_index = '0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready   = 1'b0;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        repeat (9) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) advance_search(cur_item);
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          cur_item = pending_items.pop_front();
          in_if.valid         <= 1'b1;
          in_if.op            <= cur_item.op;
          in_if.pattern_index <= cur_item.idx;
          in_if.data_byte     <= cur_item.data;
          in_if.last_byte     <= cur_item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual found=%0d offset=%0d",
                   $time, out_if.found, out_if.match_offset);
          fail_count++;
        end else begin
          result_t r;
          r = expected_results.pop_front();
          if (out_if.found !== r.found) begin
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, r.found, out_if.found);
            fail_count++;
          end
          if (out_if.match_offset !== r.offset) begin
            $display("%0t: match_offset mismatch, expected %0d actual %0d",
                     $time, r.offset, out_if.match_offset);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, QuietLimit);
    $display("exact_substring_search_top verification failed");
    $finish;
  end

  function automatic void queue_item(logic op, int idx, byte_t data, logic last, bit counts);
    search_item_t it;
    it.op   = op;
    it.idx  = idx[PidxW-1:0];
    it.data = data;
    it.last = last;
    pending_items.push_back(it);
    if (op == OpLoad) gen_pat[it.idx] = data;
    if (counts) counted++;
  endfunction

  function automatic byte_t pick_byte();
    if ($urandom_range(0, 99) < 85) return gen_alpha[$urandom_range(0, 2)];
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic drain();
    while (!(pending_items.size() == 0 && !in_if.valid && expected_results.size() == 0))
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_length(int len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len[LenW-1:0];
    @(posedge clk_i);
    model_len = len[LenW-1:0];
    cfg_we    <= 1'b0;
  endtask

  task automatic gen_search(int kind);
    byte_t bytes[$];
    int    n;
    int    keep;
    bit    with_loads;
    bit    noisy;
    with_loads = (kind >= 8);
    noisy      = (kind == 9);
    if (kind < 5 || kind == 8) begin
      n = $urandom_range(0, gen_eff + 3);
      repeat (n) bytes.push_back(pick_byte());
      for (int i = 0; i < gen_eff; i++) bytes.push_back(gen_pat[i]);
      if (bytes.size() == 0) bytes.push_back(pick_byte());
      keep = bytes.size();
      n = $urandom_range(0, 3);
      repeat (n) bytes.push_back(pick_byte());
    end else begin
      if (kind == 7) n = (gen_eff > 1) ? $urandom_range(1, gen_eff - 1) : 1;
      else if (noisy) n = $urandom_range(1, gen_eff + 8);
      else n = $urandom_range(1, 2 * gen_eff + 4);
      for (int i = 0; i < n; i++)
        bytes.push_back(noisy ? byte_t'($urandom_range(0, 255)) : pick_byte());
      keep = n;
    end
    for (int i = 0; i < bytes.size(); i++) begin
      if (with_loads && $urandom_range(0, 9) == 0)
        queue_item(OpLoad, $urandom_range(0, MaxPattern - 1), pick_byte(),
                   logic'($urandom_range(0, 1)), 1'b1);
      queue_item(OpHaystack, $urandom_range(0, MaxPattern - 1), bytes[i],
                 (i == bytes.size() - 1), (i < keep));
    end
  endtask

  task automatic run_block(int len);
    set_length(len);
    gen_eff = (len > MaxPattern) ? MaxPattern : len;
    for (int i = 0; i < 3; i++) gen_alpha[i] = byte_t'($urandom_range(0, 255));
    counted = 0;
    for (int i = 0; i < gen_eff; i++)
      queue_item(OpLoad, i, pick_byte(), logic'($urandom_range(0, 1)), 1'b1);
    while (counted < ItemsPerBlock) gen_search($urandom_range(0, 9));
  endtask

  initial begin
    int ext_len [8];
    int bi;
    int len;
    ext_len = '{0, 1, 64, 127, 65, 63, 2, 3};
    fail_count     = 0;
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < MaxPattern; i++) begin
      model_pattern[i] = '0;
      gen_pat[i]       = '0;
    end
    clear_search();
    model_len = 1;
    @(posedge rst_ni);
    @(posedge clk_i);

    // length 1 after reset: hit mid-stream, ignored tail, hit on last, miss
    queue_item(OpLoad, 0, 8'h00, 1'b1, 1'b0);
    queue_item(OpLoad, MaxPattern - 1, 8'hFF, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'hFF, 1'b0, 1'b0);
    queue_item(OpHaystack, MaxPattern - 1, 8'h00, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h00, 1'b0, 1'b0);
    queue_item(OpLoad, 0, 8'hFF, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h12, 1'b1, 1'b0);
    queue_item(OpHaystack, 0, 8'hFF, 1'b1, 1'b0);
    queue_item(OpHaystack, 0, 8'h00, 1'b1, 1'b0);
    // empty pattern
    set_length(0);
    queue_item(OpHaystack, 0, 8'hAA, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h55, 1'b1, 1'b0);
    queue_item(OpHaystack, 0, 8'h7E, 1'b1, 1'b0);
    // haystack shorter than pattern, exact fit, load during a search
    set_length(3);
    queue_item(OpLoad, 0, 8'h01, 1'b0, 1'b0);
    queue_item(OpLoad, 1, 8'h02, 1'b0, 1'b0);
    queue_item(OpLoad, 2, 8'h03, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h01, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h02, 1'b1, 1'b0);
    queue_item(OpHaystack, 0, 8'h01, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h02, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h03, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h09, 1'b1, 1'b0);
    queue_item(OpHaystack, 0, 8'h05, 1'b0, 1'b0);
    queue_item(OpLoad, 2, 8'h05, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h01, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h02, 1'b0, 1'b0);
    queue_item(OpHaystack, 0, 8'h05, 1'b1, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 50; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 50; end
        default: begin send_gap_pct = 25; sink_stall_pct = 25; end
      endcase
      for (int b = 0; b < BlocksPerPhase; b++) begin
        bi = ph * BlocksPerPhase + b;
        if (b == 0 || b == 3) len = ext_len[bi / 3];
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(9, 40);
        else len = $urandom_range(1, 8);
        run_block(len);
      end
    end

    drain();
    if (fail_count == 0)
      $display("exact_substring_search_top verification clean");
    else
      $display("exact_substring_search_top verification failed");
    $finish;
  end

endmodule
